[rtl/tdc_pkg.sv]
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types and constants for the dead-band thermostat controller.
// ----------------------------------------------------------------------------
package tdc_pkg;

  // Event codes carried in the func field
  localparam logic [2:0] FUNC_UP     = 3'd0;
  localparam logic [2:0] FUNC_DOWN   = 3'd1;
  localparam logic [2:0] FUNC_POWER  = 3'd2;
  localparam logic [2:0] FUNC_SAMPLE = 3'd3;
  localparam logic [2:0] FUNC_TICK   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_MARGIN      = 3'd0;
  localparam logic [2:0] CFG_STEP_SIZE   = 3'd1;
  localparam logic [2:0] CFG_MIN_SETPT   = 3'd2;
  localparam logic [2:0] CFG_MAX_SETPT   = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT     = 3'd4;
  localparam logic [2:0] CFG_DEFAULT_SET = 3'd5;

  // Reset values of the configuration registers
  localparam logic [5:0] MARGIN_RST      = 6'd5;
  localparam logic [3:0] STEP_SIZE_RST   = 4'd5;
  localparam logic [7:0] MIN_SETPT_RST   = 8'd35;
  localparam logic [7:0] MAX_SETPT_RST   = 8'd75;
  localparam logic [2:0] TIMEOUT_RST     = 3'd5;
  localparam logic [7:0] DEFAULT_SET_RST = 8'd60;

  // Converter reading to degrees: floor(adc * 500 / 1024)
  localparam logic [18:0] DEG_SCALE = 19'd500;
  localparam int          DEG_SHIFT = 10;

  // Idle tick counter saturates here
  localparam logic [2:0] IDLE_MAX = 3'd7;

  // Live configuration handed to the control engine
  typedef struct packed {
    logic [5:0] margin;
    logic [3:0] step_size;
    logic [7:0] min_setpoint;
    logic [7:0] max_setpoint;
    logic [2:0] timeout_ticks;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic       power_on;
    logic       heater_on;
    logic       cooler_on;
    logic       heater_led;
    logic       display_on;
    logic [8:0] display_value;
    logic       setting_mode;
    logic [7:0] setpoint_out;
  } result_t;

endpackage

[rtl/tdc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tdc_cfg_regs
// Configuration register file. The stored default setpoint acts only at
// reset, so a write to it is accepted and dropped.
// ----------------------------------------------------------------------------
module tdc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [7:0]    wr_data,
  output tdc_pkg::cfg_t cfg
);
  import tdc_pkg::*;

  cfg_t regs;

  // Write one register per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.margin        <= MARGIN_RST;
      regs.step_size     <= STEP_SIZE_RST;
      regs.min_setpoint  <= MIN_SETPT_RST;
      regs.max_setpoint  <= MAX_SETPT_RST;
      regs.timeout_ticks <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_MARGIN:    regs.margin        <= wr_data[5:0];
        CFG_STEP_SIZE: regs.step_size     <= wr_data[3:0];
        CFG_MIN_SETPT: regs.min_setpoint  <= wr_data;
        CFG_MAX_SETPT: regs.max_setpoint  <= wr_data;
        CFG_TIMEOUT:   regs.timeout_ticks <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[rtl/tdc_engine.sv]
// ----------------------------------------------------------------------------
// tdc_engine
// Controller state and its combinational update for one event word. Produces
// the result word showing the state after the event.
// ----------------------------------------------------------------------------
module tdc_engine #(
  parameter int AVG_SAMPLES = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [2:0]       func,
  input  logic [8:0]       deg,
  input  tdc_pkg::cfg_t    cfg,
  output tdc_pkg::result_t result
);
  import tdc_pkg::*;

  // Divide by AVG_SAMPLES as a multiply by a rounded-up reciprocal; exact for
  // a 13-bit dividend because the rounding error times 2^13 stays below 2^18.
  localparam int          DIV_SHIFT = 18;
  localparam logic [17:0] DIV_MULT  =
    18'(((1 << DIV_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES);
  localparam logic [4:0]  AVG_N     = 5'(AVG_SAMPLES);

  logic       powered, powered_next;
  logic [7:0] setpoint, setpoint_next;
  logic [8:0] average_temp, average_temp_next;
  logic [3:0] sample_count, sample_count_next;
  logic [12:0] sample_sum, sample_sum_next;
  logic [2:0] idle_ticks, idle_ticks_next;
  logic       up_armed, up_armed_next;
  logic       down_armed, down_armed_next;
  logic       in_setting, in_setting_next;
  logic       drive_heat, drive_heat_next;
  logic       drive_cool, drive_cool_next;
  logic       led_state, led_state_next;
  logic       display_enabled, display_enabled_next;
  logic [8:0] shown_value, shown_value_next;

  logic [12:0] sum_add;
  logic [30:0] quot_prod;
  logic [8:0]  avg_new;
  logic        window_done;
  logic [8:0]  up_sum;
  logic signed [9:0]  down_diff;
  logic signed [10:0] sp_s, lo_s, hi_s;
  logic [2:0]  idle_inc;

  // Sample accumulation and the averaged value
  assign sum_add     = sample_sum + 13'(deg);
  assign quot_prod   = 31'(sum_add) * 31'(DIV_MULT);
  assign avg_new     = quot_prod[DIV_SHIFT +: 9];
  assign window_done = (5'(sample_count) + 5'd1) >= AVG_N;

  // Dead band limits around the new average
  assign sp_s = $signed({3'b000, setpoint});
  assign lo_s = $signed({2'b00, avg_new}) - $signed({5'b00000, cfg.margin});
  assign hi_s = $signed({2'b00, avg_new}) + $signed({5'b00000, cfg.margin});

  // Setpoint steps
  assign up_sum    = {1'b0, setpoint} + {5'b00000, cfg.step_size};
  assign down_diff = $signed({2'b00, setpoint}) - $signed({6'b000000, cfg.step_size});

  assign idle_inc = (idle_ticks < IDLE_MAX) ? idle_ticks + 3'd1 : idle_ticks;

  // Next state for one event
  always_comb begin
    powered_next         = powered;
    setpoint_next        = setpoint;
    average_temp_next    = average_temp;
    sample_count_next    = sample_count;
    sample_sum_next      = sample_sum;
    idle_ticks_next      = idle_ticks;
    up_armed_next        = up_armed;
    down_armed_next      = down_armed;
    in_setting_next      = in_setting;
    drive_heat_next      = drive_heat;
    drive_cool_next      = drive_cool;
    led_state_next       = led_state;
    display_enabled_next = display_enabled;
    shown_value_next     = shown_value;

    unique case (func)
      FUNC_UP: begin
        idle_ticks_next = '0;
        if (up_armed && powered) begin
          setpoint_next = (up_sum <= {1'b0, cfg.max_setpoint}) ? up_sum[7:0]
                                                              : cfg.max_setpoint;
        end else begin
          up_armed_next = 1'b1;
        end
      end
      FUNC_DOWN: begin
        idle_ticks_next = '0;
        if (down_armed && powered) begin
          setpoint_next = (down_diff >= $signed({2'b00, cfg.min_setpoint}))
                          ? down_diff[7:0] : cfg.min_setpoint;
        end else begin
          down_armed_next = 1'b1;
        end
      end
      FUNC_POWER: begin
        if (!powered) begin
          powered_next = 1'b1;
        end else begin
          powered_next         = 1'b0;
          display_enabled_next = 1'b0;
          led_state_next       = 1'b0;
          drive_heat_next      = 1'b0;
          drive_cool_next      = 1'b0;
        end
      end
      FUNC_SAMPLE: begin
        if (powered) begin
          if (window_done) begin
            sample_count_next = '0;
            sample_sum_next   = '0;
            average_temp_next = avg_new;
            if (sp_s < hi_s && sp_s > lo_s) begin
              drive_heat_next = 1'b0;
              drive_cool_next = 1'b0;
            end else if (sp_s > lo_s) begin
              drive_heat_next = 1'b1;
              drive_cool_next = 1'b0;
            end else if (sp_s < hi_s) begin
              drive_heat_next = 1'b0;
              drive_cool_next = 1'b1;
            end
          end else begin
            sample_count_next = sample_count + 4'd1;
            sample_sum_next   = sum_add;
          end
        end
      end
      FUNC_TICK: begin
        led_state_next = powered && drive_heat && !led_state;
        if (powered) begin
          idle_ticks_next      = idle_inc;
          display_enabled_next = 1'b1;
          if (idle_inc > cfg.timeout_ticks) begin
            up_armed_next    = 1'b0;
            down_armed_next  = 1'b0;
            shown_value_next = average_temp;
            in_setting_next  = 1'b0;
          end else begin
            shown_value_next = {1'b0, setpoint};
            in_setting_next  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Commit the update when an event word fires
  always_ff @(posedge clk) begin
    if (rst) begin
      powered         <= 1'b0;
      setpoint        <= DEFAULT_SET_RST;
      average_temp    <= '0;
      sample_count    <= '0;
      sample_sum      <= '0;
      idle_ticks      <= '0;
      up_armed        <= 1'b0;
      down_armed      <= 1'b0;
      in_setting      <= 1'b0;
      drive_heat      <= 1'b0;
      drive_cool      <= 1'b0;
      led_state       <= 1'b0;
      display_enabled <= 1'b0;
      shown_value     <= '0;
    end else if (fire) begin
      powered         <= powered_next;
      setpoint        <= setpoint_next;
      average_temp    <= average_temp_next;
      sample_count    <= sample_count_next;
      sample_sum      <= sample_sum_next;
      idle_ticks      <= idle_ticks_next;
      up_armed        <= up_armed_next;
      down_armed      <= down_armed_next;
      in_setting      <= in_setting_next;
      drive_heat      <= drive_heat_next;
      drive_cool      <= drive_cool_next;
      led_state       <= led_state_next;
      display_enabled <= display_enabled_next;
      shown_value     <= shown_value_next;
    end
  end

  // Result word reflects the state after the event
  always_comb begin
    result.power_on      = powered_next;
    result.heater_on     = drive_heat_next;
    result.cooler_on     = drive_cool_next;
    result.heater_led    = led_state_next;
    result.display_on    = display_enabled_next;
    result.display_value = display_enabled_next ? shown_value_next : 9'd0;
    result.setting_mode  = in_setting_next;
    result.setpoint_out  = setpoint_next;
  end

`ifndef SYNTHESIS
  // Drives stay off while the system is off
  a_off_no_drive: assert property (@(posedge clk) disable iff (rst)
    !powered |-> (!drive_heat && !drive_cool))
    else $error("drive active while system off");

  // Heater and cooler are never driven together
  a_no_heat_cool: assert property (@(posedge clk) disable iff (rst)
    !(drive_heat && drive_cool))
    else $error("heater and cooler both on");

  // Heater LED is lit only while on
  a_led_on: assert property (@(posedge clk) disable iff (rst)
    led_state |-> powered)
    else $error("heater LED lit while off");

  // Any up press leaves the up direction armed
  a_up_arms: assert property (@(posedge clk) disable iff (rst)
    (fire && func == FUNC_UP) |=> up_armed)
    else $error("up press did not arm");

  // Any down press leaves the down direction armed
  a_down_arms: assert property (@(posedge clk) disable iff (rst)
    (fire && func == FUNC_DOWN) |=> down_armed)
    else $error("down press did not arm");
`endif

endmodule

[rtl/thermostat_deadband_controller_core.sv]
// ----------------------------------------------------------------------------
// thermostat_deadband_controller_core
// Event-driven bang-bang thermostat with a dead band around the averaged
// temperature, setpoint buttons with arming, and tick-driven display control.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   in       | in        | in_valid/in_ready  | func, adc_sample
//   out      | out       | out_valid/out_ready| power_on .. setpoint_out
//   cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One event word per cycle sustained while out_ready holds high; each word
// passes the input register, then the state update into the result register.
// The input register scales the converter reading; the state update is the
// logic between it and the result register.
// A stalled result register holds and the input register still takes a word
// until it is full. Reset is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
module thermostat_deadband_controller_core #(
  parameter int AVG_SAMPLES = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] func,
  input  logic [9:0] adc_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       power_on,
  output logic       heater_on,
  output logic       cooler_on,
  output logic       heater_led,
  output logic       display_on,
  output logic [8:0] display_value,
  output logic       setting_mode,
  output logic [7:0] setpoint_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tdc_pkg::*;

  cfg_t        cfg;
  result_t     result;
  result_t     out_word;
  logic        in_hold;
  logic [2:0]  in_func;
  logic [8:0]  in_deg;
  logic        advance;
  logic        fire;
  logic [18:0] deg_prod;

  assign cfg_ready = 1'b1;

  tdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline moves when the result register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign fire     = in_hold && advance;
  assign in_ready = !in_hold || advance;

  // Scale the reading to degrees on entry
  assign deg_prod = 19'(adc_sample) * DEG_SCALE;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_hold <= 1'b0;
    end else if (in_ready) begin
      in_hold <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_func <= func;
      in_deg  <= deg_prod[DEG_SHIFT +: 9];
    end
  end

  tdc_engine #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .func   (in_func),
    .deg    (in_deg),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= result;
    end
  end

  assign power_on      = out_word.power_on;
  assign heater_on     = out_word.heater_on;
  assign cooler_on     = out_word.cooler_on;
  assign heater_led    = out_word.heater_led;
  assign display_on    = out_word.display_on;
  assign display_value = out_word.display_value;
  assign setting_mode  = out_word.setting_mode;
  assign setpoint_out  = out_word.setpoint_out;

`ifndef SYNTHESIS
  // A shown value needs an enabled display
  a_disp_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && display_value != 9'd0) |-> display_on)
    else $error("display value while display off");

  // A held input word moves into the result register when it frees
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("fired word not presented");

  // Drives never both on in a result word
  a_out_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(heater_on && cooler_on))
    else $error("result drives heater and cooler");
`endif

endmodule
